// ===== rtl/pfwc_pkg.sv =====
// Shared types and constants for the packet framer with weighted checksum.
`default_nettype none
package pfwc_pkg;

  localparam int MAX_PAYLOAD_DEFAULT = 64;
  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam int PKT_LEN_W = 7;
  localparam int SUM_W = 32;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_DESC    = 1'b1;
  localparam logic TYPE_DATA    = 1'b0;
  localparam logic TYPE_LAST    = 1'b1;

  typedef struct packed {
    logic                 has_payload;
    logic                 has_desc;
    logic [7:0]           payload_byte;
    logic                 packet_type;
    logic [PKT_LEN_W-1:0] packet_length;
    logic [SUM_W-1:0]     packet_checksum;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic                 kind;
    logic [7:0]           payload_byte;
    logic                 packet_type;
    logic [PKT_LEN_W-1:0] packet_length;
    logic [SUM_W-1:0]     packet_checksum;
    logic                 last_result;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/pfwc_front.sv =====
// Front end: accepts bytes, tracks the open packet and builds queue entries.
`default_nettype none
module pfwc_front import pfwc_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire logic   has_byte,
  input  wire logic   [7:0] data_byte,
  input  wire logic   end_of_message,
  input  wire logic   q_full,
  output logic        wr,
  output entry_t      wr_entry
);

  localparam int POS_W = $clog2(MAX_PAYLOAD + 1);
  localparam int EXT_W = (POS_W > PKT_LEN_W) ? POS_W : PKT_LEN_W;
  localparam int PROD_W = 8 + POS_W;

  logic [POS_W-1:0]  position;
  logic [SUM_W-1:0]  checksum;
  logic [POS_W-1:0]  position_next;
  logic [SUM_W-1:0]  checksum_next;
  logic [POS_W-1:0]  pos_inc;
  logic [POS_W-1:0]  weight;
  logic [PROD_W-1:0] product;
  logic [SUM_W-1:0]  sum_inc;
  logic [EXT_W-1:0]  len_ext;
  logic              accept;
  logic              closes;

  assign accept  = push && !q_full;
  assign pos_inc = position + POS_W'(1);
  assign weight  = position[0] ? (position - POS_W'(1)) : pos_inc;
  assign product = {{POS_W{1'b0}}, data_byte} * {8'd0, weight};
  assign sum_inc = checksum + SUM_W'(product);
  assign closes  = end_of_message || (pos_inc >= POS_W'(MAX_PAYLOAD));
  assign wr      = accept && (has_byte || end_of_message);

  always_comb begin
    position_next = position;
    checksum_next = checksum;
    wr_entry      = '0;
    len_ext       = EXT_W'(position);
    if (has_byte) begin
      len_ext                  = EXT_W'(pos_inc);
      wr_entry.has_payload     = 1'b1;
      wr_entry.payload_byte    = data_byte;
      wr_entry.has_desc        = closes;
      wr_entry.packet_type     = end_of_message ? TYPE_LAST : TYPE_DATA;
      wr_entry.packet_length   = len_ext[PKT_LEN_W-1:0];
      wr_entry.packet_checksum = sum_inc;
      if (closes) begin
        position_next = '0;
        checksum_next = '0;
      end else begin
        position_next = pos_inc;
        checksum_next = sum_inc;
      end
    end else if (end_of_message) begin
      wr_entry.has_desc        = 1'b1;
      wr_entry.packet_type     = TYPE_LAST;
      wr_entry.packet_length   = len_ext[PKT_LEN_W-1:0];
      wr_entry.packet_checksum = checksum;
      position_next            = '0;
      checksum_next            = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      checksum <= '0;
    end else if (accept) begin
      position <= position_next;
      checksum <= checksum_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pfwc_queue.sv =====
// Short queue of framed entries between the front end and the result stage.
`default_nettype none
module pfwc_queue import pfwc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  entry_t    wr_entry,
  input  wire logic rd,
  output entry_t    rd_entry,
  output q_status_t status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t        store [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);
  assign do_wr        = wr && !status.full;
  assign do_rd        = rd && !status.empty;
  assign rd_entry     = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pfwc_back.sv =====
// Result stage: splits each entry into payload and descriptor results.
`default_nettype none
module pfwc_back import pfwc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  entry_t    rd_entry,
  input  wire logic q_empty,
  output logic      rd,
  input  wire logic pop,
  output logic      empty,
  output result_t   result
);

  logic    out_valid;
  logic    phase;
  logic    load;
  logic    send_payload;
  result_t next_result;

  assign empty        = !out_valid;
  assign load         = !q_empty && (!out_valid || pop);
  assign send_payload = rd_entry.has_payload && !phase;
  assign rd           = load && !(send_payload && rd_entry.has_desc);

  always_comb begin
    next_result = '0;
    if (send_payload) begin
      next_result.kind         = KIND_PAYLOAD;
      next_result.payload_byte = rd_entry.payload_byte;
      next_result.last_result  = !rd_entry.has_desc;
    end else begin
      next_result.kind            = KIND_DESC;
      next_result.packet_type     = rd_entry.packet_type;
      next_result.packet_length   = rd_entry.packet_length;
      next_result.packet_checksum = rd_entry.packet_checksum;
      next_result.last_result     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= next_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= !rd;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/packet_framer_weighted_checksum.sv =====
// Top level of the packet framer with position-weighted checksum.
// One request is accepted per clock while full is low; the front end updates
// the packet position and the checksum (one small multiply and a 32-bit add)
// in the cycle of acceptance and writes a framed entry into a QUEUE_DEPTH
// deep queue. The result stage delivers one result per clock while pop is
// high; a byte that closes a packet yields a payload and a descriptor result,
// so full can rise behind a stalled consumer or a run of such bytes. Each
// entry passes the queue and then the result register on its way out.
`default_nettype none
module packet_framer_weighted_checksum import pfwc_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic                 has_byte,
  input  wire logic [7:0]           data_byte,
  input  wire logic                 end_of_message,
  input  wire logic                 pop,
  output logic                      empty,
  output logic                      kind,
  output logic [7:0]                payload_byte,
  output logic                      packet_type,
  output logic [PKT_LEN_W-1:0]      packet_length,
  output logic [SUM_W-1:0]          packet_checksum,
  output logic                      last_result
);

  entry_t    wr_entry;
  entry_t    rd_entry;
  q_status_t q_status;
  result_t   result;
  logic      wr;
  logic      rd;

  pfwc_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .has_byte       (has_byte),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .q_full         (q_status.full),
    .wr             (wr),
    .wr_entry       (wr_entry)
  );

  pfwc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .wr_entry (wr_entry),
    .rd       (rd),
    .rd_entry (rd_entry),
    .status   (q_status)
  );

  pfwc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .rd_entry (rd_entry),
    .q_empty  (q_status.empty),
    .rd       (rd),
    .pop      (pop),
    .empty    (empty),
    .result   (result)
  );

  assign full            = q_status.full;
  assign kind            = result.kind;
  assign payload_byte    = result.payload_byte;
  assign packet_type     = result.packet_type;
  assign packet_length   = result.packet_length;
  assign packet_checksum = result.packet_checksum;
  assign last_result     = result.last_result;

endmodule
`default_nettype wire

// ===== rtl/pfwc_checker.sv =====
// Port-level checks of the framer results, bound to the top level.
`default_nettype none
module pfwc_checker import pfwc_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 pop,
  input wire logic                 empty,
  input wire logic                 kind,
  input wire logic [7:0]           payload_byte,
  input wire logic                 packet_type,
  input wire logic [PKT_LEN_W-1:0] packet_length,
  input wire logic [SUM_W-1:0]     packet_checksum,
  input wire logic                 last_result
);

  localparam logic [PKT_LEN_W-1:0] FULL_LEN = PKT_LEN_W'(MAX_PAYLOAD);

  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("results shown right after reset");

  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == KIND_PAYLOAD) |->
      (packet_type == TYPE_DATA && packet_length == '0 && packet_checksum == '0))
    else $error("payload result carries descriptor fields");

  a_desc_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == KIND_DESC) |-> (last_result && payload_byte == 8'd0))
    else $error("descriptor result is not the final result of its request");

  a_data_full: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == KIND_DESC && packet_type == TYPE_DATA) |->
      (packet_length == FULL_LEN))
    else $error("data packet closed before it was full");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(kind) && $stable(packet_checksum)))
    else $error("waiting result changed before it was taken");

endmodule

bind packet_framer_weighted_checksum pfwc_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_pfwc_checker (.*);
`default_nettype wire

// ===== test/tb_packet_framer_weighted_checksum.sv =====
// Self-checking testbench for the packet framer with position-weighted checksum.
module tb_packet_framer_weighted_checksum;
  timeunit 1ns;
  timeprecision 1ps;
  import pfwc_pkg::*;

  localparam int PACKET_BYTES = MAX_PAYLOAD_DEFAULT;
  localparam int TOTAL_ITEMS = 550;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] data_byte;
    logic       end_of_message;
  } frame_req_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 has_byte = 1'b0;
  logic [7:0]           data_byte = 8'h00;
  logic                 end_of_message = 1'b0;
  logic                 pop = 1'b0;
  logic                 full;
  logic                 empty;
  logic                 kind;
  logic [7:0]           payload_byte;
  logic                 packet_type;
  logic [PKT_LEN_W-1:0] packet_length;
  logic [SUM_W-1:0]     packet_checksum;
  logic                 last_result;

  frame_req_t pending_requests[$];
  result_t    framed_results_due[$];

  logic [31:0] open_position = '0;
  logic [31:0] open_checksum = '0;

  int queued_items = 0;
  int accepted_count = 0;
  int accepted_bytes = 0;
  int accepted_markers = 0;
  int results_seen = 0;
  int data_packets = 0;
  int last_packets = 0;
  int full_packets = 0;
  int error_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  logic receiver_hold = 1'b0;
  int idle_cycles = 0;

  packet_framer_weighted_checksum u_top (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .has_byte        (has_byte),
    .data_byte       (data_byte),
    .end_of_message  (end_of_message),
    .pop             (pop),
    .empty           (empty),
    .kind            (kind),
    .payload_byte    (payload_byte),
    .packet_type     (packet_type),
    .packet_length   (packet_length),
    .packet_checksum (packet_checksum),
    .last_result     (last_result)
  );

  always #5 clk = ~clk;

  task automatic close_open_packet(input logic ptype);
    result_t r;
    r = '0;
    r.kind = KIND_DESC;
    r.packet_type = ptype;
    r.packet_length = open_position[PKT_LEN_W-1:0];
    r.packet_checksum = open_checksum;
    r.last_result = 1'b1;
    framed_results_due.push_back(r);
    open_position = '0;
    open_checksum = '0;
  endtask

  task automatic frame_request(input frame_req_t req);
    result_t     r;
    logic [31:0] weight;
    logic        closes;
    if (req.has_byte) begin
      weight = open_position[0] ? open_position - 32'd1 : open_position + 32'd1;
      open_checksum = open_checksum + {24'd0, req.data_byte} * weight;
      open_position = open_position + 32'd1;
      closes = req.end_of_message || (open_position >= PACKET_BYTES);
      r = '0;
      r.kind = KIND_PAYLOAD;
      r.payload_byte = req.data_byte;
      r.last_result = !closes;
      framed_results_due.push_back(r);
      if (closes) close_open_packet(req.end_of_message ? TYPE_LAST : TYPE_DATA);
    end else if (req.end_of_message) begin
      close_open_packet(TYPE_LAST);
    end
  endtask

  task automatic add_request(input logic hb, input logic [7:0] db, input logic eom);
    frame_req_t req;
    req.has_byte = hb;
    req.data_byte = db;
    req.end_of_message = eom;
    pending_requests.push_back(req);
    queued_items++;
  endtask

  task automatic add_message(input int len, input bit bare_end);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) add_request(1'b0, 8'($urandom), 1'b0);
      add_request(1'b1, 8'($urandom), (i == len - 1) && !bare_end);
    end
    if (bare_end || len == 0) add_request(1'b0, 8'($urandom), 1'b1);
  endtask

  always @(posedge clk) begin : drive_requests
    logic       next_push;
    frame_req_t next_req;
    bit         calm;
    next_push = push;
    next_req = '{has_byte, data_byte, end_of_message};
    calm = (accepted_count >= 300 && accepted_count < 420) || receiver_hold;
    if (rst) begin
      next_push = 1'b0;
    end else begin
      if (push && !full) begin
        frame_request(next_req);
        accepted_count++;
        if (next_req.has_byte) accepted_bytes++;
        else if (next_req.end_of_message) accepted_markers++;
        next_push = 1'b0;
      end
      if (!next_push && pending_requests.size() > 0 &&
          (calm || $urandom_range(0, 99) >= 25)) begin
        next_req = pending_requests.pop_front();
        next_push = 1'b1;
      end
    end
    push <= next_push;
    has_byte <= next_req.has_byte;
    data_byte <= next_req.data_byte;
    end_of_message <= next_req.end_of_message;
  end

  always @(posedge clk) begin : check_results
    result_t want;
    bit      calm;
    if (rst) begin
      pop <= 1'b0;
      receiver_hold <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_seen++;
        if (kind == KIND_DESC) begin
          if (packet_type == TYPE_LAST) last_packets++;
          else data_packets++;
          if (packet_length == PKT_LEN_W'(PACKET_BYTES)) full_packets++;
        end
        if (framed_results_due.size() == 0) begin
          $error("unexpected result: kind %0d, byte %h, type %0d, length %0d, checksum %h",
                 kind, payload_byte, packet_type, packet_length, packet_checksum);
          error_count++;
        end else begin
          want = framed_results_due.pop_front();
          if (kind !== want.kind) begin
            $error("kind mismatch: expected %0d, actual %0d", want.kind, kind);
            error_count++;
          end
          if (payload_byte !== want.payload_byte) begin
            $error("payload_byte mismatch: expected %h, actual %h",
                   want.payload_byte, payload_byte);
            error_count++;
          end
          if (packet_type !== want.packet_type) begin
            $error("packet_type mismatch: expected %0d, actual %0d",
                   want.packet_type, packet_type);
            error_count++;
          end
          if (packet_length !== want.packet_length) begin
            $error("packet_length mismatch: expected %0d, actual %0d",
                   want.packet_length, packet_length);
            error_count++;
          end
          if (packet_checksum !== want.packet_checksum) begin
            $error("packet_checksum mismatch: expected %h, actual %h",
                   want.packet_checksum, packet_checksum);
            error_count++;
          end
          if (last_result !== want.last_result) begin
            $error("last_result mismatch: expected %0d, actual %0d",
                   want.last_result, last_result);
            error_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && results_seen >= 150) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      calm = results_seen >= 300 && results_seen < 420;
      pop <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 25);
      receiver_hold <= (hold_left != 0);
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("packet_framer_weighted_checksum regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : run_test
    int len_pick;
    int len;
    add_request(1'b0, 8'h3C, 1'b1);
    add_request(1'b0, 8'hFF, 1'b0);
    add_request(1'b0, 8'h00, 1'b0);
    add_request(1'b1, 8'hFF, 1'b1);
    add_request(1'b1, 8'h00, 1'b0);
    add_request(1'b1, 8'hFF, 1'b0);
    add_request(1'b1, 8'hFF, 1'b0);
    add_request(1'b1, 8'h80, 1'b0);
    add_request(1'b0, 8'h5A, 1'b1);
    add_request(1'b1, 8'h01, 1'b0);
    add_request(1'b1, 8'hFE, 1'b1);
    add_request(1'b1, 8'h12, 1'b0);
    add_request(1'b0, 8'hC3, 1'b0);
    add_request(1'b1, 8'h34, 1'b1);
    add_request(1'b0, 8'hA5, 1'b1);
    add_request(1'b0, 8'h7E, 1'b1);
    add_request(1'b1, 8'h55, 1'b0);
    add_request(1'b1, 8'hAA, 1'b0);
    add_request(1'b1, 8'h7F, 1'b0);
    add_request(1'b1, 8'h01, 1'b1);
    add_message(PACKET_BYTES, 1'b0);
    add_message(PACKET_BYTES, 1'b1);
    while (queued_items < TOTAL_ITEMS) begin
      len_pick = $urandom_range(0, 11);
      case (len_pick)
        0: len = 0;
        1: len = PACKET_BYTES;
        2: len = $urandom_range(PACKET_BYTES - 1, PACKET_BYTES + 1);
        3: len = $urandom_range(1, 2 * PACKET_BYTES);
        default: len = $urandom_range(1, 20);
      endcase
      add_message(len, $urandom_range(0, 3) == 0);
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (pending_requests.size() != 0 || push) @(posedge clk);
    while (framed_results_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (framed_results_due.size() != 0) begin
      $error("%0d expected results never arrived", framed_results_due.size());
      error_count++;
    end
    $display("Covered %0d requests (%0d bytes, %0d bare end markers) and %0d results,",
             accepted_count, accepted_bytes, accepted_markers, results_seen);
    $display("closing %0d data and %0d last packets, %0d of them at full length.",
             data_packets, last_packets, full_packets);
    if (error_count == 0) begin
      $display("packet_framer_weighted_checksum regression: pass");
    end else begin
      $display("packet_framer_weighted_checksum regression: fail");
    end
    $finish;
  end

endmodule
